[rtl/core/cpu8x_pkg.sv]
// Package for the 8-bit execute stage: operation codes, flag positions,
// and payload types for input and result items. No dependencies.
package cpu8x_pkg;

  typedef enum logic [5:0] {
    OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3,  OP_BCS = 6'd4,
    OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7,  OP_BNE = 6'd8,  OP_BPL = 6'd9,
    OP_BRK = 6'd10, OP_BVC = 6'd11, OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14,
    OP_CLI = 6'd15, OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19,
    OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23, OP_INC = 6'd24,
    OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27, OP_JSR = 6'd28, OP_LDA = 6'd29,
    OP_LDX = 6'd30, OP_LDY = 6'd31, OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34,
    OP_PHA = 6'd35, OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39,
    OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43, OP_SEC = 6'd44,
    OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47, OP_STX = 6'd48, OP_STY = 6'd49,
    OP_TAX = 6'd50, OP_TAY = 6'd51, OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54,
    OP_TYA = 6'd55
  } op_e;

  localparam int unsigned FC = 0;
  localparam int unsigned FZ = 1;
  localparam int unsigned FI = 2;
  localparam int unsigned FD = 3;
  localparam int unsigned FB = 4;
  localparam int unsigned FU = 5;
  localparam int unsigned FV = 6;
  localparam int unsigned FN = 7;

  localparam logic [7:0]  StatusReset = 8'h20;
  localparam logic [15:0] StackBase   = 16'h0100;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  operand;
    logic [15:0] target_address;
    logic        accumulator_mode;
    logic [15:0] next_pc;
    logic [7:0]  stack_byte_first;
    logic [7:0]  stack_byte_second;
    logic [7:0]  stack_byte_third;
    logic [15:0] break_vector;
  } in_item_t;

  typedef struct packed {
    logic        is_write;
    logic [15:0] write_address;
    logic [7:0]  write_data;
    logic [7:0]  acc_value;
    logic [7:0]  x_value;
    logic [7:0]  y_value;
    logic [7:0]  sp_value;
    logic [7:0]  status_value;
    logic [15:0] pc_value;
    logic [2:0]  cycle_cost;
    logic        last;
  } out_item_t;

endpackage

[rtl/core/cpu8x_if.sv]
// Valid/ready channel interface carrying one payload struct.
// Depends on cpu8x_pkg for the payload types.
interface cpu8x_in_if;
  logic                valid;
  logic                ready;
  cpu8x_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cpu8x_out_if;
  logic                 valid;
  logic                 ready;
  cpu8x_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/cpu8_instruction_execute.sv]
// Execute stage of the 8-bit processor: register file, ALU and write queue.
// Depends on cpu8x_pkg and the channel interfaces in cpu8x_if.sv.
//
// channel  dir  payload
// in_if    in   operation, operand, address, next PC, stack bytes, vector
// out_if   out  memory writes (0..3) then one register report with last=1
//
// An item is taken into the input register, executed into a result queue
// of four entries, and drained one result per cycle while out_if is ready,
// so items without writes run at one per cycle; BRK and JSR wait on writes.
// Reset clears the registers (status 0x20) and empties both stages.
// A stalled output holds the queue; input is taken while it has room.
module cpu8_instruction_execute (
  input  logic              clk_i,
  input  logic              rst_ni,
  cpu8x_in_if.sink          in_if,
  cpu8x_out_if.source       out_if
);

  cpu8x_pkg::in_item_t  item_q;
  logic                 item_vld_q;
  cpu8x_pkg::out_item_t res_q [4];
  cpu8x_pkg::out_item_t res_d [4];
  logic [2:0]           res_cnt_q;
  logic [1:0]           res_idx_q;

  logic [7:0]  a_q, x_q, y_q, sp_q, p_q;
  logic [7:0]  a_d, x_d, y_d, sp_d, p_d;
  logic [15:0] pc_d;
  logic [2:0]  cost;
  logic [1:0]  nwr;
  logic [15:0] wa [3];
  logic [7:0]  wd [3];

  logic        exec;
  logic        drain_done;
  logic        pop;

  assign pop        = out_if.valid && out_if.ready;
  assign drain_done = (res_cnt_q == 3'd0) ||
                      (pop && ({1'b0, res_idx_q} == res_cnt_q - 3'd1));
  assign exec       = item_vld_q && drain_done;
  assign in_if.ready = !item_vld_q || exec;

  always_comb begin
    logic [7:0]  m, r, s1, lo8;
    logic [8:0]  bin, sb;
    logic [4:0]  lo;
    logic [9:0]  hi;
    logic [5:0]  slo;
    logic [9:0]  shi;
    logic [15:0] t, v, npc;
    logic        c, tk, isbr, setnz;
    m   = item_q.operand;
    t   = item_q.target_address;
    s1  = item_q.stack_byte_first;
    c   = p_q[cpu8x_pkg::FC];
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; p_d = p_q;
    pc_d = item_q.next_pc;
    cost = 3'd1; nwr = 2'd0;
    r = 8'h00; setnz = 1'b0; tk = 1'b0; isbr = 1'b0;
    lo8 = 8'h00; v = 16'h0000; npc = 16'h0000;
    for (int i = 0; i < 3; i++) begin
      wa[i] = 16'h0000; wd[i] = 8'h00;
    end
    bin = {1'b0, a_q} + {1'b0, m} + {8'h00, c};
    sb  = {1'b0, a_q} + {1'b0, ~m} + {8'h00, c};
    lo  = {1'b0, a_q[3:0]} + {1'b0, m[3:0]} + {4'h0, c};
    hi  = {2'b00, a_q[7:4], 4'h0} + {2'b00, m[7:4], 4'h0};
    slo = {2'b00, a_q[3:0]} - {2'b00, m[3:0]} - {5'h00, !c};
    shi = {2'b00, a_q[7:4], 4'h0} - {2'b00, m[7:4], 4'h0};
    unique case (item_q.kind) inside
      cpu8x_pkg::OP_ADC: begin
        if (p_q[cpu8x_pkg::FD]) begin
          p_d[cpu8x_pkg::FZ] = (bin[7:0] == 8'h00);
          if (lo > 5'd9) begin
            lo = lo + 5'd6; hi = hi + 10'h010;
          end
          p_d[cpu8x_pkg::FN] = hi[7];
          p_d[cpu8x_pkg::FV] = !(a_q[7] ^ m[7]) && (a_q[7] ^ hi[7]);
          if (hi > 10'h090) hi = hi + 10'h060;
          p_d[cpu8x_pkg::FC] = hi[9] | hi[8];
          a_d = {hi[7:4], lo[3:0]};
        end else begin
          p_d[cpu8x_pkg::FC] = bin[8];
          p_d[cpu8x_pkg::FV] = !(a_q[7] ^ m[7]) && (a_q[7] ^ bin[7]);
          r = bin[7:0]; setnz = 1'b1; a_d = bin[7:0];
        end
      end
      cpu8x_pkg::OP_SBC: begin
        p_d[cpu8x_pkg::FC] = sb[8];
        p_d[cpu8x_pkg::FV] = (a_q[7] ^ m[7]) && (a_q[7] ^ sb[7]);
        r = sb[7:0]; setnz = 1'b1;
        if (p_q[cpu8x_pkg::FD]) begin
          if (slo[4]) begin
            slo = slo - 6'd6; shi = shi - 10'd1;
          end
          if (shi[8]) shi = shi - 10'h060;
          a_d = {shi[7:4], slo[3:0]};
        end else begin
          a_d = sb[7:0];
        end
      end
      cpu8x_pkg::OP_AND: begin a_d = a_q & m; r = a_d; setnz = 1'b1; end
      cpu8x_pkg::OP_EOR: begin a_d = a_q ^ m; r = a_d; setnz = 1'b1; end
      cpu8x_pkg::OP_ORA: begin a_d = a_q | m; r = a_d; setnz = 1'b1; end
      cpu8x_pkg::OP_ASL, cpu8x_pkg::OP_LSR, cpu8x_pkg::OP_ROL, cpu8x_pkg::OP_ROR: begin
        case (item_q.kind)
          cpu8x_pkg::OP_ASL: begin r = {m[6:0], 1'b0}; p_d[cpu8x_pkg::FC] = m[7]; end
          cpu8x_pkg::OP_ROL: begin r = {m[6:0], c};    p_d[cpu8x_pkg::FC] = m[7]; end
          cpu8x_pkg::OP_LSR: begin r = {1'b0, m[7:1]}; p_d[cpu8x_pkg::FC] = m[0]; end
          default:           begin r = {c, m[7:1]};    p_d[cpu8x_pkg::FC] = m[0]; end
        endcase
        setnz = 1'b1;
        if (item_q.accumulator_mode) begin
          a_d = r;
        end else begin
          nwr = 2'd1; wa[0] = t; wd[0] = r; cost = 3'd2;
        end
      end
      cpu8x_pkg::OP_BCC: begin isbr = 1'b1; tk = !c; end
      cpu8x_pkg::OP_BCS: begin isbr = 1'b1; tk = c; end
      cpu8x_pkg::OP_BEQ: begin isbr = 1'b1; tk = p_q[cpu8x_pkg::FZ]; end
      cpu8x_pkg::OP_BNE: begin isbr = 1'b1; tk = !p_q[cpu8x_pkg::FZ]; end
      cpu8x_pkg::OP_BMI: begin isbr = 1'b1; tk = p_q[cpu8x_pkg::FN]; end
      cpu8x_pkg::OP_BPL: begin isbr = 1'b1; tk = !p_q[cpu8x_pkg::FN]; end
      cpu8x_pkg::OP_BVS: begin isbr = 1'b1; tk = p_q[cpu8x_pkg::FV]; end
      cpu8x_pkg::OP_BVC: begin isbr = 1'b1; tk = !p_q[cpu8x_pkg::FV]; end
      cpu8x_pkg::OP_BIT: begin
        p_d[cpu8x_pkg::FZ] = ((a_q & m) == 8'h00);
        p_d[cpu8x_pkg::FV] = m[6];
        p_d[cpu8x_pkg::FN] = m[7];
      end
      cpu8x_pkg::OP_BRK: begin
        v = item_q.next_pc + 16'd1;
        nwr = 2'd3;
        wa[0] = cpu8x_pkg::StackBase | {8'h00, sp_q};
        wa[1] = cpu8x_pkg::StackBase | {8'h00, sp_q - 8'd1};
        wa[2] = cpu8x_pkg::StackBase | {8'h00, sp_q - 8'd2};
        wd[0] = v[15:8]; wd[1] = v[7:0];
        wd[2] = p_q | 8'h30;
        sp_d = sp_q - 8'd3;
        p_d = p_q | 8'h14;
        pc_d = item_q.break_vector;
        cost = 3'd6;
      end
      cpu8x_pkg::OP_CLC: p_d[cpu8x_pkg::FC] = 1'b0;
      cpu8x_pkg::OP_CLD: p_d[cpu8x_pkg::FD] = 1'b0;
      cpu8x_pkg::OP_CLI: p_d[cpu8x_pkg::FI] = 1'b0;
      cpu8x_pkg::OP_CLV: p_d[cpu8x_pkg::FV] = 1'b0;
      cpu8x_pkg::OP_SEC: p_d[cpu8x_pkg::FC] = 1'b1;
      cpu8x_pkg::OP_SED: p_d[cpu8x_pkg::FD] = 1'b1;
      cpu8x_pkg::OP_SEI: p_d[cpu8x_pkg::FI] = 1'b1;
      cpu8x_pkg::OP_CMP, cpu8x_pkg::OP_CPX, cpu8x_pkg::OP_CPY: begin
        case (item_q.kind)
          cpu8x_pkg::OP_CMP: lo8 = a_q;
          cpu8x_pkg::OP_CPX: lo8 = x_q;
          default:           lo8 = y_q;
        endcase
        p_d[cpu8x_pkg::FC] = (lo8 >= m);
        r = lo8 - m; setnz = 1'b1;
      end
      cpu8x_pkg::OP_DEC: begin
        r = m - 8'd1; setnz = 1'b1; nwr = 2'd1; wa[0] = t; wd[0] = r; cost = 3'd3;
      end
      cpu8x_pkg::OP_INC: begin
        r = m + 8'd1; setnz = 1'b1; nwr = 2'd1; wa[0] = t; wd[0] = r; cost = 3'd3;
      end
      cpu8x_pkg::OP_DEX: begin x_d = x_q - 8'd1; r = x_d; setnz = 1'b1; end
      cpu8x_pkg::OP_DEY: begin y_d = y_q - 8'd1; r = y_d; setnz = 1'b1; end
      cpu8x_pkg::OP_INX: begin x_d = x_q + 8'd1; r = x_d; setnz = 1'b1; end
      cpu8x_pkg::OP_INY: begin y_d = y_q + 8'd1; r = y_d; setnz = 1'b1; end
      cpu8x_pkg::OP_JMP: pc_d = t;
      cpu8x_pkg::OP_JSR: begin
        v = item_q.next_pc - 16'd1;
        nwr = 2'd2;
        wa[0] = cpu8x_pkg::StackBase | {8'h00, sp_q};
        wa[1] = cpu8x_pkg::StackBase | {8'h00, sp_q - 8'd1};
        wd[0] = v[15:8]; wd[1] = v[7:0];
        sp_d = sp_q - 8'd2; pc_d = t; cost = 3'd3;
      end
      cpu8x_pkg::OP_LDA: begin a_d = m; r = m; setnz = 1'b1; end
      cpu8x_pkg::OP_LDX: begin x_d = m; r = m; setnz = 1'b1; end
      cpu8x_pkg::OP_LDY: begin y_d = m; r = m; setnz = 1'b1; end
      cpu8x_pkg::OP_NOP: cost = 3'd1;
      cpu8x_pkg::OP_PHA, cpu8x_pkg::OP_PHP: begin
        nwr = 2'd1; wa[0] = cpu8x_pkg::StackBase | {8'h00, sp_q};
        wd[0] = (item_q.kind == cpu8x_pkg::OP_PHA) ? a_q : p_q;
        sp_d = sp_q - 8'd1; cost = 3'd2;
      end
      cpu8x_pkg::OP_PLA: begin
        a_d = s1; sp_d = sp_q + 8'd1; r = s1; setnz = 1'b1; cost = 3'd3;
      end
      cpu8x_pkg::OP_PLP: begin
        p_d = s1 | 8'h20; sp_d = sp_q + 8'd1; cost = 3'd3;
      end
      cpu8x_pkg::OP_RTI: begin
        p_d = s1 | 8'h20;
        pc_d = {item_q.stack_byte_third, item_q.stack_byte_second};
        sp_d = sp_q + 8'd3; cost = 3'd5;
      end
      cpu8x_pkg::OP_RTS: begin
        pc_d = {item_q.stack_byte_second, s1} + 16'd1;
        sp_d = sp_q + 8'd2; cost = 3'd5;
      end
      cpu8x_pkg::OP_STA: begin nwr = 2'd1; wa[0] = t; wd[0] = a_q; end
      cpu8x_pkg::OP_STX: begin nwr = 2'd1; wa[0] = t; wd[0] = x_q; end
      cpu8x_pkg::OP_STY: begin nwr = 2'd1; wa[0] = t; wd[0] = y_q; end
      cpu8x_pkg::OP_TAX: begin x_d = a_q; r = a_q; setnz = 1'b1; end
      cpu8x_pkg::OP_TAY: begin y_d = a_q; r = a_q; setnz = 1'b1; end
      cpu8x_pkg::OP_TSX: begin x_d = sp_q; r = sp_q; setnz = 1'b1; end
      cpu8x_pkg::OP_TXA: begin a_d = x_q; r = x_q; setnz = 1'b1; end
      cpu8x_pkg::OP_TXS: sp_d = x_q;
      cpu8x_pkg::OP_TYA: begin a_d = y_q; r = y_q; setnz = 1'b1; end
      default: cost = 3'd0;
    endcase
    if (setnz) begin
      p_d[cpu8x_pkg::FZ] = (r == 8'h00);
      p_d[cpu8x_pkg::FN] = r[7];
    end
    if (isbr && tk) begin
      npc  = item_q.next_pc + t;
      pc_d = npc;
      cost = ((npc[15:8] ^ item_q.next_pc[15:8]) != 8'h00) ? 3'd3 : 3'd2;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) res_d[i] = '0;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < nwr) begin
        res_d[i].is_write      = 1'b1;
        res_d[i].write_address = wa[i];
        res_d[i].write_data    = wd[i];
      end
    end
    res_d[nwr] = '{is_write: 1'b0, write_address: 16'h0000, write_data: 8'h00,
                   acc_value: a_d, x_value: x_d, y_value: y_d, sp_value: sp_d,
                   status_value: p_d, pc_value: pc_d, cycle_cost: cost,
                   last: 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_cnt_q  <= 3'd0;
      res_idx_q  <= 2'd0;
      a_q  <= 8'h00; x_q <= 8'h00; y_q <= 8'h00; sp_q <= 8'h00;
      p_q  <= cpu8x_pkg::StatusReset;
    end else begin
      if (exec) begin
        res_idx_q <= 2'd0;
      end else if (pop) begin
        res_idx_q <= res_idx_q + 2'd1;
      end
      if (drain_done && !exec) res_cnt_q <= 3'd0;
      if (exec) begin
        a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; p_q <= p_d;
        res_cnt_q <= {1'b0, nwr} + 3'd1;
      end
      if (in_if.ready) item_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) res_q <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) item_q <= in_if.data;
  end

  assign out_if.valid = (res_cnt_q != 3'd0);
  assign out_if.data  = res_q[res_idx_q];

endmodule

[test/cpu8_instruction_execute_checker.sv]
`timescale 1ns / 100ps
// Checker for the 8-bit execute stage: watches both channels, predicts each
// instruction's writes and register report, and counts mismatches.
// Depends on cpu8x_pkg and the channel interfaces in cpu8x_if.sv.
module cpu8_instruction_execute_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  cpu8x_in_if         in_if,
  cpu8x_out_if        out_if,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  logic [7:0]  reg_a, reg_x, reg_y, reg_sp, reg_p;
  logic [15:0] reg_pc;
  cpu8x_pkg::out_item_t expected_q[$];
  int unsigned fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic void put_nz(input logic [7:0] v);
    reg_p[cpu8x_pkg::FZ] = (v == 8'h00);
    reg_p[cpu8x_pkg::FN] = v[7];
  endfunction

  function automatic void queue_write(input logic [15:0] addr, input logic [7:0] data);
    cpu8x_pkg::out_item_t w;
    w = '0;
    w.is_write      = 1'b1;
    w.write_address = addr;
    w.write_data    = data;
    expected_q.push_back(w);
  endfunction

  function automatic void push_stack(input logic [7:0] v);
    queue_write(cpu8x_pkg::StackBase | {8'h00, reg_sp}, v);
    reg_sp = reg_sp - 8'd1;
  endfunction

  function automatic logic [2:0] take_branch(input logic cond, input logic [15:0] disp);
    logic [15:0] nw;
    if (!cond) return 3'd1;
    nw = reg_pc + disp;
    take_branch = ((nw ^ reg_pc) & 16'hFF00) != 0 ? 3'd3 : 3'd2;
    reg_pc = nw;
  endfunction

  function automatic logic [2:0] shift_result(input logic [7:0] r, input logic acc_mode,
                                              input logic [15:0] addr);
    put_nz(r);
    if (acc_mode) begin
      reg_a = r;
      return 3'd1;
    end
    queue_write(addr, r);
    return 3'd2;
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
    reg_p[cpu8x_pkg::FC] = (r >= m);
    put_nz(r - m);
  endfunction

  function automatic void add_with_carry(input logic [7:0] m);
    int unsigned a, c, bin, lo, hi;
    a = reg_a; c = reg_p[cpu8x_pkg::FC]; bin = a + m + c;
    if (reg_p[cpu8x_pkg::FD]) begin
      lo = (a & 'hF) + (m & 'hF) + c;
      hi = (a & 'hF0) + (m & 'hF0);
      reg_p[cpu8x_pkg::FZ] = (bin & 'hFF) == 0;
      if (lo > 9) begin
        lo += 6; hi += 'h10;
      end
      reg_p[cpu8x_pkg::FN] = (hi & 'h80) != 0;
      reg_p[cpu8x_pkg::FV] = (~(a ^ m) & (a ^ hi) & 'h80) != 0;
      if (hi > 'h90) hi += 'h60;
      reg_p[cpu8x_pkg::FC] = hi > 'hFF;
      reg_a = 8'((hi & 'hF0) | (lo & 'hF));
    end else begin
      reg_p[cpu8x_pkg::FC] = bin > 'hFF;
      reg_p[cpu8x_pkg::FV] = (~(a ^ m) & (a ^ bin) & 'h80) != 0;
      put_nz(8'(bin));
      reg_a = 8'(bin);
    end
  endfunction

  function automatic void subtract_with_borrow(input logic [7:0] m);
    int unsigned a, c, bin, lo, hi;
    a = reg_a; c = reg_p[cpu8x_pkg::FC]; bin = a + (m ^ 8'hFF) + c;
    reg_p[cpu8x_pkg::FC] = bin > 'hFF;
    reg_p[cpu8x_pkg::FV] = ((a ^ m) & (a ^ bin) & 'h80) != 0;
    put_nz(8'(bin));
    if (reg_p[cpu8x_pkg::FD]) begin
      lo = (a & 'hF) - (m & 'hF) - (1 - c);
      hi = (a & 'hF0) - (m & 'hF0);
      if (lo & 'h10) begin
        lo -= 6; hi -= 1;
      end
      if (hi & 'h100) hi -= 'h60;
      reg_a = 8'((hi & 'hF0) | (lo & 'hF));
    end else begin
      reg_a = 8'(bin);
    end
  endfunction

  function automatic void execute_instr(input cpu8x_pkg::in_item_t it);
    logic [7:0]  p, m;
    logic [15:0] t, v;
    logic [2:0]  cost;
    cpu8x_pkg::out_item_t rep;
    p = reg_p; m = it.operand; t = it.target_address; cost = 3'd1;
    reg_pc = it.next_pc;
    if (it.kind > cpu8x_pkg::OP_TYA) begin
      cost = 3'd0;
    end else begin
      case (cpu8x_pkg::op_e'(it.kind))
        cpu8x_pkg::OP_ADC: add_with_carry(m);
        cpu8x_pkg::OP_AND: begin reg_a = reg_a & m; put_nz(reg_a); end
        cpu8x_pkg::OP_ASL: begin
          reg_p[cpu8x_pkg::FC] = m[7];
          cost = shift_result({m[6:0], 1'b0}, it.accumulator_mode, t);
        end
        cpu8x_pkg::OP_BCC: cost = take_branch(!p[cpu8x_pkg::FC], t);
        cpu8x_pkg::OP_BCS: cost = take_branch(p[cpu8x_pkg::FC], t);
        cpu8x_pkg::OP_BEQ: cost = take_branch(p[cpu8x_pkg::FZ], t);
        cpu8x_pkg::OP_BIT: begin
          reg_p[cpu8x_pkg::FZ] = (reg_a & m) == 0;
          reg_p[cpu8x_pkg::FV] = m[6];
          reg_p[cpu8x_pkg::FN] = m[7];
        end
        cpu8x_pkg::OP_BMI: cost = take_branch(p[cpu8x_pkg::FN], t);
        cpu8x_pkg::OP_BNE: cost = take_branch(!p[cpu8x_pkg::FZ], t);
        cpu8x_pkg::OP_BPL: cost = take_branch(!p[cpu8x_pkg::FN], t);
        cpu8x_pkg::OP_BRK: begin
          v = reg_pc + 16'd1;
          push_stack(v[15:8]); push_stack(v[7:0]);
          push_stack(p | 8'h30);
          reg_p[cpu8x_pkg::FI] = 1'b1; reg_p[cpu8x_pkg::FB] = 1'b1;
          reg_pc = it.break_vector; cost = 3'd6;
        end
        cpu8x_pkg::OP_BVC: cost = take_branch(!p[cpu8x_pkg::FV], t);
        cpu8x_pkg::OP_BVS: cost = take_branch(p[cpu8x_pkg::FV], t);
        cpu8x_pkg::OP_CLC: reg_p[cpu8x_pkg::FC] = 1'b0;
        cpu8x_pkg::OP_CLD: reg_p[cpu8x_pkg::FD] = 1'b0;
        cpu8x_pkg::OP_CLI: reg_p[cpu8x_pkg::FI] = 1'b0;
        cpu8x_pkg::OP_CLV: reg_p[cpu8x_pkg::FV] = 1'b0;
        cpu8x_pkg::OP_CMP: compare_reg(reg_a, m);
        cpu8x_pkg::OP_CPX: compare_reg(reg_x, m);
        cpu8x_pkg::OP_CPY: compare_reg(reg_y, m);
        cpu8x_pkg::OP_DEC: begin
          queue_write(t, m - 8'd1); put_nz(m - 8'd1); cost = 3'd3;
        end
        cpu8x_pkg::OP_DEX: begin reg_x = reg_x - 8'd1; put_nz(reg_x); end
        cpu8x_pkg::OP_DEY: begin reg_y = reg_y - 8'd1; put_nz(reg_y); end
        cpu8x_pkg::OP_EOR: begin reg_a = reg_a ^ m; put_nz(reg_a); end
        cpu8x_pkg::OP_INC: begin
          queue_write(t, m + 8'd1); put_nz(m + 8'd1); cost = 3'd3;
        end
        cpu8x_pkg::OP_INX: begin reg_x = reg_x + 8'd1; put_nz(reg_x); end
        cpu8x_pkg::OP_INY: begin reg_y = reg_y + 8'd1; put_nz(reg_y); end
        cpu8x_pkg::OP_JMP: reg_pc = t;
        cpu8x_pkg::OP_JSR: begin
          v = reg_pc - 16'd1;
          push_stack(v[15:8]); push_stack(v[7:0]);
          reg_pc = t; cost = 3'd3;
        end
        cpu8x_pkg::OP_LDA: begin reg_a = m; put_nz(m); end
        cpu8x_pkg::OP_LDX: begin reg_x = m; put_nz(m); end
        cpu8x_pkg::OP_LDY: begin reg_y = m; put_nz(m); end
        cpu8x_pkg::OP_LSR: begin
          reg_p[cpu8x_pkg::FC] = m[0];
          cost = shift_result({1'b0, m[7:1]}, it.accumulator_mode, t);
        end
        cpu8x_pkg::OP_NOP: ;
        cpu8x_pkg::OP_ORA: begin reg_a = reg_a | m; put_nz(reg_a); end
        cpu8x_pkg::OP_PHA: begin push_stack(reg_a); cost = 3'd2; end
        cpu8x_pkg::OP_PHP: begin push_stack(p); cost = 3'd2; end
        cpu8x_pkg::OP_PLA: begin
          reg_a = it.stack_byte_first; reg_sp = reg_sp + 8'd1;
          put_nz(reg_a); cost = 3'd3;
        end
        cpu8x_pkg::OP_PLP: begin
          reg_p = it.stack_byte_first | 8'h20; reg_sp = reg_sp + 8'd1; cost = 3'd3;
        end
        cpu8x_pkg::OP_ROL: begin
          reg_p[cpu8x_pkg::FC] = m[7];
          cost = shift_result({m[6:0], p[cpu8x_pkg::FC]}, it.accumulator_mode, t);
        end
        cpu8x_pkg::OP_ROR: begin
          reg_p[cpu8x_pkg::FC] = m[0];
          cost = shift_result({p[cpu8x_pkg::FC], m[7:1]}, it.accumulator_mode, t);
        end
        cpu8x_pkg::OP_RTI: begin
          reg_p  = it.stack_byte_first | 8'h20;
          reg_pc = {it.stack_byte_third, it.stack_byte_second};
          reg_sp = reg_sp + 8'd3; cost = 3'd5;
        end
        cpu8x_pkg::OP_RTS: begin
          reg_pc = {it.stack_byte_second, it.stack_byte_first} + 16'd1;
          reg_sp = reg_sp + 8'd2; cost = 3'd5;
        end
        cpu8x_pkg::OP_SBC: subtract_with_borrow(m);
        cpu8x_pkg::OP_SEC: reg_p[cpu8x_pkg::FC] = 1'b1;
        cpu8x_pkg::OP_SED: reg_p[cpu8x_pkg::FD] = 1'b1;
        cpu8x_pkg::OP_SEI: reg_p[cpu8x_pkg::FI] = 1'b1;
        cpu8x_pkg::OP_STA: queue_write(t, reg_a);
        cpu8x_pkg::OP_STX: queue_write(t, reg_x);
        cpu8x_pkg::OP_STY: queue_write(t, reg_y);
        cpu8x_pkg::OP_TAX: begin reg_x = reg_a; put_nz(reg_x); end
        cpu8x_pkg::OP_TAY: begin reg_y = reg_a; put_nz(reg_y); end
        cpu8x_pkg::OP_TSX: begin reg_x = reg_sp; put_nz(reg_x); end
        cpu8x_pkg::OP_TXA: begin reg_a = reg_x; put_nz(reg_a); end
        cpu8x_pkg::OP_TXS: reg_sp = reg_x;
        cpu8x_pkg::OP_TYA: begin reg_a = reg_y; put_nz(reg_a); end
        default: cost = 3'd0;
      endcase
    end
    rep = '0;
    rep.acc_value    = reg_a;
    rep.x_value      = reg_x;
    rep.y_value      = reg_y;
    rep.sp_value     = reg_sp;
    rep.status_value = reg_p;
    rep.pc_value     = reg_pc;
    rep.cycle_cost   = cost;
    rep.last         = 1'b1;
    expected_q.push_back(rep);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cpu8x_pkg::out_item_t want;
    if (!rst_ni) begin
      reg_a = '0; reg_x = '0; reg_y = '0; reg_sp = '0;
      reg_p = cpu8x_pkg::StatusReset; reg_pc = '0;
      fails <= 0;
      expected_q.delete();
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          if (fails < 10) $display("%0t: unexpected result %p", $time, out_if.data);
          fails <= fails + 1;
        end else begin
          want = expected_q.pop_front();
          if (out_if.data !== want) begin
            if (fails < 10)
              $display("%0t: mismatch expected %p actual %p", $time, want, out_if.data);
            fails <= fails + 1;
          end
        end
      end
      if (in_if.valid && in_if.ready) execute_instr(in_if.data);
    end
  end
endmodule

[test/cpu8_instruction_execute_tb.sv]
`timescale 1ns / 100ps
// Testbench top for the 8-bit execute stage: clock, reset, directed and
// random instruction stimulus, random output stalls, and the verdict.
// Depends on cpu8x_pkg, cpu8x_if.sv, the block and its checker.
module cpu8_instruction_execute_tb;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned fail_count, pending;
  int          idle_left = 0;
  logic        calm = 1'b0;

  cpu8x_in_if  in_if ();
  cpu8x_out_if out_if ();

  cpu8_instruction_execute i_dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if));

  cpu8_instruction_execute_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_if(in_if), .out_if(out_if),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (calm) begin
      out_if.ready <= 1'b1;
    end else if (idle_left > 0) begin
      idle_left    <= idle_left - 1;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      idle_left    <= $urandom_range(1, 13);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  function automatic cpu8x_pkg::in_item_t random_instr();
    cpu8x_pkg::in_item_t it;
    logic [95:0]         raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(cpu8x_pkg::in_item_t)-1:0];
    it.kind = 6'(($urandom_range(0, 19) == 0) ? $urandom_range(56, 63) : $urandom_range(0, 55));
    return it;
  endfunction

  task automatic send_instr(input cpu8x_pkg::in_item_t it, input logic gaps);
    logic taken;
    if (gaps && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    do begin
      @(negedge clk_i);
      taken = in_if.ready;
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_op(input cpu8x_pkg::op_e op, input logic [7:0] m,
                         input logic [15:0] t, input logic acc_mode);
    cpu8x_pkg::in_item_t it;
    it = random_instr();
    it.kind = op; it.operand = m; it.target_address = t; it.accumulator_mode = acc_mode;
    send_instr(it, 1'b1);
  endtask

  initial begin
    cpu8x_pkg::in_item_t it;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_op(cpu8x_pkg::OP_LDA, 8'h00, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_LDX, 8'hFF, 16'hFFFF, 1'b0);
    send_op(cpu8x_pkg::OP_SED, 8'h00, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_ADC, 8'h99, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_ADC, 8'hFA, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_SBC, 8'h9F, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_CLD, 8'h00, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_SBC, 8'h80, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_BRK, 8'h00, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_JSR, 8'h00, 16'hFFFF, 1'b0);
    send_op(cpu8x_pkg::OP_BNE, 8'h00, 16'hFF80, 1'b0);
    send_op(cpu8x_pkg::OP_BEQ, 8'h00, 16'h007F, 1'b0);
    send_op(cpu8x_pkg::OP_ROR, 8'h01, 16'h1234, 1'b0);
    send_op(cpu8x_pkg::OP_ROR, 8'h80, 16'h0000, 1'b1);
    send_op(cpu8x_pkg::OP_ASL, 8'hFF, 16'hFFFF, 1'b0);
    send_op(cpu8x_pkg::OP_LSR, 8'h01, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_PLP, 8'h00, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_RTI, 8'h00, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_TXS, 8'h00, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::OP_PHA, 8'h00, 16'h0000, 1'b0);
    send_op(cpu8x_pkg::op_e'(6'd63), 8'hFF, 16'hFFFF, 1'b1);
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    for (int n = 0; n < 100; n++) begin
      if (n == 75) begin
        in_if.valid <= 1'b0;
        calm = 1'b1;
        @(posedge clk_i);
      end
      it = random_instr();
      if ($urandom_range(0, 3) == 0) it.operand = $urandom_range(0, 1) ? 8'h99 : 8'h00;
      send_instr(it, !calm);
    end
    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("cpu8_instruction_execute regression: pass");
    end else begin
      $display("cpu8_instruction_execute regression: fail");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("cpu8_instruction_execute regression: fail");
    $finish;
  end
endmodule

[files.f]
rtl/core/cpu8x_pkg.sv
rtl/core/cpu8x_if.sv
rtl/core/cpu8_instruction_execute.sv
test/cpu8_instruction_execute_checker.sv
test/cpu8_instruction_execute_tb.sv
